[hw/rtl/srlg_pkg.sv]
// shared types and constants for the seeded lcg range generator
`timescale 1ns / 1ps

package srlg_pkg;

   localparam int STATE_W = 64;
   localparam int VALUE_W = 16;
   localparam int RANGE_W = VALUE_W + 1;
   localparam int DIGIT_W = 8;

   localparam logic [STATE_W-1:0] MUL64 = 64'd6364136223846793005;
   localparam logic [STATE_W-1:0] INC64 = 64'd1;
   localparam logic [STATE_W-1:0] MUL31 = 64'd214013;
   localparam logic [STATE_W-1:0] INC31 = 64'd2531011;

   // generator modes
   localparam logic MODE_LCG64 = 1'b0;
   localparam logic MODE_LCG31 = 1'b1;

   // register indexes
   localparam logic CSR_SEED_INIT = 1'b0;
   localparam logic CSR_GEN_MODE  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_RNG,
      ST_EMIT
   } ctrl_state_type;

endpackage

[hw/rtl/srlg_lcg_mul.sv]
// lcg state update, one 8-bit digit of the multiplier constant per cycle
`timescale 1ns / 1ps

module srlg_lcg_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          mode,
   input  logic [srlg_pkg::STATE_W-1:0]  seed,
   output logic                          done,
   output logic [srlg_pkg::STATE_W-1:0]  product
);

   logic                         busy_ff, busy_in;
   logic [2:0]                   count_ff, count_in;
   logic                         mode_ff, mode_in;
   logic [srlg_pkg::STATE_W-1:0] mcand_ff, mcand_in;
   logic [srlg_pkg::STATE_W-1:0] acc_ff, acc_in;

   logic [srlg_pkg::STATE_W-1:0] mult_const;
   logic [srlg_pkg::STATE_W-1:0] inc_const;
   logic [srlg_pkg::DIGIT_W-1:0] digit;
   logic [srlg_pkg::STATE_W-1:0] part;
   logic                         last;
   logic [srlg_pkg::STATE_W-1:0] step_sum;

   always_comb begin
      mult_const = (mode_ff == srlg_pkg::MODE_LCG31) ? srlg_pkg::MUL31 : srlg_pkg::MUL64;
      inc_const  = (mode_ff == srlg_pkg::MODE_LCG31) ? srlg_pkg::INC31 : srlg_pkg::INC64;
      // msb digit first
      digit      = mult_const[{~count_ff, 3'b000} +: srlg_pkg::DIGIT_W];
      part       = mcand_ff * digit;
      last       = (count_ff == 3'd7);
      step_sum   = (acc_ff << srlg_pkg::DIGIT_W) + part + (last ? inc_const : '0);
      done       = busy_ff && last;
      product    = (mode_ff == srlg_pkg::MODE_LCG31) ? {33'd0, step_sum[30:0]} : step_sum;
   end

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      mode_in  = mode_ff;
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         mode_in  = mode;
         mcand_in = seed;
         acc_in   = '0;
      end else if (busy_ff) begin
         acc_in   = step_sum;
         count_in = count_ff + 3'd1;
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      mode_ff  <= mode_in;
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
   end

endmodule

[hw/rtl/srlg_range_unit.sv]
// range mapping: digit-serial scale multiply or bit-serial restoring modulo
`timescale 1ns / 1ps

module srlg_range_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          mode,
   input  logic [srlg_pkg::STATE_W-1:0]  lcg_state,
   input  logic [srlg_pkg::RANGE_W-1:0]  range_size,
   output logic                          done,
   output logic [srlg_pkg::VALUE_W-1:0]  offset
);

   logic                         busy_ff, busy_in;
   logic                         mode_ff, mode_in;
   logic [3:0]                   count_ff, count_in;
   logic [srlg_pkg::RANGE_W-1:0] range_ff, range_in;
   logic [30:0]                  frac_ff, frac_in;
   logic [23:0]                  src_ff, src_in;
   logic [47:0]                  acc_ff, acc_in;

   logic [srlg_pkg::DIGIT_W-1:0] digit;
   logic [47:0]                  scale_part;
   logic [47:0]                  scale_sum;
   logic [17:0]                  trial;
   logic                         fits;
   logic [17:0]                  rem_next;
   logic [47:0]                  step_val;
   logic [3:0]                   last_count;
   logic                         last;

   always_comb begin
      digit      = src_ff[23:16];
      scale_part = frac_ff * digit;
      scale_sum  = (acc_ff << srlg_pkg::DIGIT_W) + scale_part;
      // restoring step: bring down the next dividend bit
      trial      = {acc_ff[16:0], src_ff[23]};
      fits       = (trial >= {1'b0, range_ff});
      rem_next   = fits ? (trial - {1'b0, range_ff}) : trial;
      step_val   = (mode_ff == srlg_pkg::MODE_LCG31) ? {30'd0, rem_next} : scale_sum;
      last_count = (mode_ff == srlg_pkg::MODE_LCG31) ? 4'd14 : 4'd2;
      last       = (count_ff == last_count);
      done       = busy_ff && last;
      offset     = (mode_ff == srlg_pkg::MODE_LCG31) ? step_val[15:0] : step_val[46:31];
   end

   always_comb begin
      busy_in  = busy_ff;
      mode_in  = mode_ff;
      count_in = count_ff;
      range_in = range_ff;
      frac_in  = frac_ff;
      src_in   = src_ff;
      acc_in   = acc_ff;
      if (start) begin
         busy_in  = 1'b1;
         mode_in  = mode;
         count_in = '0;
         range_in = range_size;
         frac_in  = lcg_state[51:21];
         acc_in   = '0;
         if (mode == srlg_pkg::MODE_LCG31) begin
            src_in = {lcg_state[30:16], 9'd0};
         end else begin
            src_in = {7'd0, range_size};
         end
      end else if (busy_ff) begin
         acc_in   = step_val;
         count_in = count_ff + 4'd1;
         if (mode_ff == srlg_pkg::MODE_LCG31) begin
            src_in = src_ff << 1;
         end else begin
            src_in = src_ff << srlg_pkg::DIGIT_W;
         end
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      mode_ff  <= mode_in;
      range_ff <= range_in;
      frac_ff  <= frac_in;
      src_ff   <= src_in;
      acc_ff   <= acc_in;
   end

endmodule

[hw/rtl/seeded_lcg_range_generator_core.sv]
// top level: request control, generator state, config registers, result register
// one transaction at a time: lcg update (one constant byte per cycle), then scale multiply
// (64-bit mode) or restoring modulo (31-bit mode), then into the result register; the
// response register is loaded from it while results are not stalled, and a new request
// is taken only after that, back in the idle state.
// synchronous reset clears control, the generator state and the mode; no clearing pass.
`timescale 1ns / 1ps

module seeded_lcg_range_generator_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [srlg_pkg::VALUE_W-1:0]  req_range_low,
   input  logic [srlg_pkg::VALUE_W-1:0]  req_range_high,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [srlg_pkg::VALUE_W-1:0]  rsp_rand_value,
   output logic                          rsp_bad_range,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [srlg_pkg::STATE_W-1:0]  csr_write_data
);

   srlg_pkg::ctrl_state_type state_ff, state_in;

   logic [srlg_pkg::STATE_W-1:0] lcg_state_ff, lcg_state_in;
   logic                         gen_mode_ff, gen_mode_in;
   logic [srlg_pkg::VALUE_W-1:0] low_ff, low_in;
   logic [srlg_pkg::VALUE_W-1:0] high_ff, high_in;
   logic [srlg_pkg::VALUE_W-1:0] result_ff, result_in;
   logic                         result_bad_ff, result_bad_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [srlg_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                         rsp_bad_ff, rsp_bad_in;

   logic                         mul_start;
   logic                         mul_done;
   logic [srlg_pkg::STATE_W-1:0] mul_product;
   logic                         rng_done;
   logic [srlg_pkg::VALUE_W-1:0] rng_offset;
   logic [srlg_pkg::RANGE_W-1:0] range_size;
   logic                         bad;
   logic                         out_free;
   logic                         load_rsp;

   srlg_lcg_mul u_lcg_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mode    (gen_mode_ff),
      .seed    (lcg_state_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   srlg_range_unit u_range_unit (
      .clock      (clock),
      .reset      (reset),
      .start      (mul_done),
      .mode       (gen_mode_ff),
      .lcg_state  (mul_product),
      .range_size (range_size),
      .done       (rng_done),
      .offset     (rng_offset)
   );

   always_comb begin
      bad        = (high_ff < low_ff);
      // wraps when the range is inverted, the offset is dropped then
      range_size = {1'b0, high_ff} + {{srlg_pkg::VALUE_W{1'b0}}, 1'b1} - {1'b0, low_ff};
      out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srlg_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = srlg_pkg::ST_MUL;
            end
         end
         srlg_pkg::ST_MUL: begin
            if (mul_done) begin
               state_in = srlg_pkg::ST_RNG;
            end
         end
         srlg_pkg::ST_RNG: begin
            if (rng_done) begin
               state_in = srlg_pkg::ST_EMIT;
            end
         end
         srlg_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = srlg_pkg::ST_IDLE;
            end
         end
         default: state_in = srlg_pkg::ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_stall = 1'b1;
      mul_start = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         srlg_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            mul_start = req_valid;
         end
         srlg_pkg::ST_MUL: begin
         end
         srlg_pkg::ST_RNG: begin
         end
         srlg_pkg::ST_EMIT: begin
            load_rsp = out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      lcg_state_in  = lcg_state_ff;
      gen_mode_in   = gen_mode_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      result_in     = result_ff;
      result_bad_in = result_bad_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_bad_in    = rsp_bad_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            srlg_pkg::CSR_SEED_INIT: lcg_state_in = csr_write_data;
            srlg_pkg::CSR_GEN_MODE:  gen_mode_in  = csr_write_data[0];
            default: begin
            end
         endcase
      end

      if (mul_start) begin
         low_in  = req_range_low;
         high_in = req_range_high;
      end

      if (mul_done) begin
         lcg_state_in = mul_product;
      end

      if (rng_done) begin
         result_in     = low_ff + (bad ? {srlg_pkg::VALUE_W{1'b0}} : rng_offset);
         result_bad_in = bad;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = result_ff;
         rsp_bad_in   = result_bad_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srlg_pkg::ST_IDLE;
         lcg_state_ff <= '0;
         gen_mode_ff  <= srlg_pkg::MODE_LCG64;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lcg_state_ff <= lcg_state_in;
         gen_mode_ff  <= gen_mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      low_ff        <= low_in;
      high_ff       <= high_in;
      result_ff     <= result_in;
      result_bad_ff <= result_bad_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_bad_ff    <= rsp_bad_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rand_value = rsp_value_ff;
   assign rsp_bad_range  = rsp_bad_ff;

endmodule

[verif/srlg_draw_checker.sv]
// transaction monitor, draw predictor and result comparison for the lcg range generator
`timescale 1ns / 1ps

module srlg_draw_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [srlg_pkg::VALUE_W-1:0]  req_range_low,
   input  logic [srlg_pkg::VALUE_W-1:0]  req_range_high,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [srlg_pkg::VALUE_W-1:0]  rsp_rand_value,
   input  logic                          rsp_bad_range,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [srlg_pkg::STATE_W-1:0]  csr_write_data,
   output int                            failures,
   output int                            pending
);

   localparam logic [63:0] LCG64_MUL = 64'd6364136223846793005;
   localparam logic [63:0] LCG64_INC = 64'd1;
   localparam logic [63:0] LCG31_MUL = 64'd214013;
   localparam logic [63:0] LCG31_INC = 64'd2531011;

   typedef struct packed {
      logic [15:0] value;
      logic        bad;
   } draw_type;

   logic [63:0] lcg_state;
   logic        gen_mode;
   draw_type    expected_draws[$];

   // advances the generator by one step and returns the draw it yields
   function automatic draw_type predict_draw(input logic [15:0] low, input logic [15:0] high);
      draw_type    d;
      logic [16:0] span;
      logic [30:0] frac;
      logic [47:0] scaled;
      logic [16:0] offset;
      d.bad = high < low;
      span = d.bad ? 17'd1 : ({1'b0, high} + 17'd1 - {1'b0, low});
      if (gen_mode == srlg_pkg::MODE_LCG64) begin
         lcg_state = lcg_state * LCG64_MUL + LCG64_INC;
         frac = lcg_state[51:21];
         scaled = {17'd0, frac} * {31'd0, span};
         offset = scaled[47:31];
      end else begin
         lcg_state = {33'd0, 31'(lcg_state * LCG31_MUL + LCG31_INC)};
         offset = {2'b00, lcg_state[30:16]} % span;
      end
      if (d.bad) offset = '0;
      d.value = low + offset[15:0];
      return d;
   endfunction

   always @(posedge clock) begin
      draw_type want;
      if (reset) begin
         lcg_state = '0;
         gen_mode = srlg_pkg::MODE_LCG64;
         expected_draws.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == srlg_pkg::CSR_SEED_INIT)
               lcg_state = csr_write_data;
            else if (csr_index == srlg_pkg::CSR_GEN_MODE)
               gen_mode = csr_write_data[0];
         end
         if (req_valid && !req_stall)
            expected_draws.push_back(predict_draw(req_range_low, req_range_high));
         if (rsp_valid && !rsp_stall) begin
            if (expected_draws.size() == 0) begin
               $display("%0t: unexpected transaction: rand_value %0d bad_range %0b",
                        $time, rsp_rand_value, rsp_bad_range);
               failures <= failures + 1;
            end else begin
               want = expected_draws.pop_front();
               if (rsp_rand_value !== want.value || rsp_bad_range !== want.bad) begin
                  if (rsp_rand_value !== want.value)
                     $display("%0t: rand_value mismatch: expected %0d, actual %0d",
                              $time, want.value, rsp_rand_value);
                  if (rsp_bad_range !== want.bad)
                     $display("%0t: bad_range mismatch: expected %0b, actual %0b",
                              $time, want.bad, rsp_bad_range);
                  failures <= failures + 1;
               end
            end
         end
      end
      pending <= expected_draws.size();
   end

endmodule

[verif/tb.sv]
// testbench top: clock, reset, request and register stimulus, result stalls and verdict
`timescale 1ns / 1ps

module tb;

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int SETTLE_CYCLES   = 40;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_range_low;
   logic [15:0] req_range_high;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_rand_value;
   logic        rsp_bad_range;
   logic        csr_write_enable;
   logic        csr_index;
   logic [63:0] csr_write_data;
   int          failures;
   int          pending;

   bit          send_quiet;
   bit          recv_quiet;

   seeded_lcg_range_generator_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_range_low    (req_range_low),
      .req_range_high   (req_range_high),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_rand_value   (rsp_rand_value),
      .rsp_bad_range    (rsp_bad_range),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   srlg_draw_checker u_draw_chk (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_range_low    (req_range_low),
      .req_range_high   (req_range_high),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_rand_value   (rsp_rand_value),
      .rsp_bad_range    (rsp_bad_range),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .failures         (failures),
      .pending          (pending)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // called and returns at a falling edge; valid stays high when the next gap is zero
   task automatic push_request(input logic [15:0] low, input logic [15:0] high);
      int gap;
      if ($urandom_range(0, 19) == 0) send_quiet = ~send_quiet;
      gap = send_quiet ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_range_low <= low;
      req_range_high <= high;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [63:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // sender holds off until every outstanding transaction has returned
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // result side: a fresh stall length is drawn after every accepted transaction
   initial begin
      int  stall_left;
      bit  taken;
      stall_left = 0;
      recv_quiet = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         taken = rsp_valid && !rsp_stall;
         @(negedge clock);
         if (taken) begin
            if ($urandom_range(0, 19) == 0) recv_quiet = ~recv_quiet;
            stall_left = recv_quiet ? 0 : $urandom_range(0, 16);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      logic [15:0] low;
      logic [15:0] high;
      logic [15:0] a;
      logic [15:0] b;
      logic [63:0] seed;
      send_quiet = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_range_low <= '0;
      req_range_high <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= srlg_pkg::CSR_SEED_INIT;
      csr_write_data <= '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // state and mode straight out of reset
      push_request(16'd0, 16'hffff);
      push_request(16'd0, 16'd0);
      push_request(16'hffff, 16'hffff);
      push_request(16'hffff, 16'd0);
      push_request(16'd1, 16'd0);
      push_request(16'd0, 16'd1);
      push_request(16'h8000, 16'hffff);
      push_request(16'd12345, 16'd12345);
      wait_drained();

      // 31-bit generator from an all-ones seed; upper data bits must not leak into the mode
      write_reg(srlg_pkg::CSR_SEED_INIT, 64'hffff_ffff_ffff_ffff);
      write_reg(srlg_pkg::CSR_GEN_MODE, {63'h7fff_ffff_ffff_ffff, srlg_pkg::MODE_LCG31});
      push_request(16'd0, 16'hffff);
      push_request(16'd0, 16'd0);
      push_request(16'hffff, 16'hffff);
      push_request(16'hffff, 16'd0);
      push_request(16'd100, 16'd99);
      push_request(16'd0, 16'd1);
      push_request(16'd0, 16'h7fff);
      wait_drained();

      write_reg(srlg_pkg::CSR_GEN_MODE, {63'h2aaa_aaaa_aaaa_aaaa, srlg_pkg::MODE_LCG64});
      write_reg(srlg_pkg::CSR_SEED_INIT, 64'h8000_0000_0000_0000);
      push_request(16'd0, 16'hffff);
      push_request(16'd1, 16'hfffe);
      push_request(16'd40000, 16'd2);
      push_request(16'd0, 16'd2);
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         case ($urandom_range(0, 3))
            0:       seed = '0;
            1:       seed = '1;
            default: seed = {$urandom, $urandom};
         endcase
         write_reg(srlg_pkg::CSR_GEN_MODE, {$urandom, 31'($urandom_range(0, 32'h7fff_ffff)),
                   phase[0] ? srlg_pkg::MODE_LCG31 : srlg_pkg::MODE_LCG64});
         write_reg(srlg_pkg::CSR_SEED_INIT, seed);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            a = 16'($urandom);
            b = 16'($urandom);
            case ($urandom_range(0, 9))
               0: begin
                  // inverted bounds
                  low = 16'($urandom_range(1, 16'hffff));
                  high = 16'($urandom_range(0, low - 1));
               end
               1: begin
                  low = a;
                  high = a;
               end
               2: begin
                  low = $urandom_range(0, 1) ? 16'd0 : a;
                  high = $urandom_range(0, 1) ? 16'hffff : b;
               end
               3, 4: begin
                  low = a;
                  high = (a > 16'hfff0) ? 16'hffff : a + 16'($urandom_range(0, 15));
               end
               5: begin
                  low = a;
                  high = b;
               end
               default: begin
                  low = (a < b) ? a : b;
                  high = (a < b) ? b : a;
               end
            endcase
            push_request(low, high);
            if (n == ITEMS_PER_PHASE / 2 && phase % 3 == 1) wait_drained();
         end
         wait_drained();
      end

      if (failures == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
